FILE: rtl/core/mset_pkg.sv
package mset_pkg;

	localparam int FRAC_BITS = 28;
	localparam int LOG_DEPTH = 256;
	localparam int LOG_BITS = $clog2(LOG_DEPTH);
	localparam logic [31:0] NEG_LOG2_LN2 = 32'd2271034279;

	typedef enum logic [3:0] {
		S_IDLE,
		S_COORD,
		S_CHECK,
		S_MUL,
		S_TEST,
		S_UPD,
		S_NORM,
		S_LOG,
		S_PROD,
		S_DIV,
		S_QUO,
		S_DONE
	} state_t;

	typedef enum logic [1:0] {
		M_XX,
		M_YY,
		M_XY
	} msel_t;

	typedef logic [2:0] cfg_idx_t;
	localparam cfg_idx_t CFG_X_MIN     = 3'd0;
	localparam cfg_idx_t CFG_Y_MAX     = 3'd1;
	localparam cfg_idx_t CFG_X_STEP    = 3'd2;
	localparam cfg_idx_t CFG_Y_STEP    = 3'd3;
	localparam cfg_idx_t CFG_MAX_ITER  = 3'd4;
	localparam cfg_idx_t CFG_COLORS    = 3'd5;
	localparam cfg_idx_t CFG_RADIUS_SQ = 3'd6;

	typedef logic [31:0] logtab_t [LOG_DEPTH];

	// log2(1 + k/depth) in q0.32 by repeated squaring of a q2.30 value
	function automatic logtab_t build_log_tab();
		logtab_t t;
		logic [63:0] y;
		logic [31:0] frac;
		for (int k = 0; k < LOG_DEPTH; k++) begin
			y = (64'(LOG_DEPTH + k) << 30) >> LOG_BITS;
			frac = '0;
			for (int b = 0; b < 32; b++) begin
				y = (y * y) >> 30;
				if (y >= (64'd1 << 31)) begin
					y = y >> 1;
					frac[31 - b] = 1'b1;
				end
			end
			t[k] = frac;
		end
		return t;
	endfunction

	localparam logtab_t LOG_TAB = build_log_tab();

endpackage

FILE: rtl/core/mset_mul.sv
module mset_mul import mset_pkg::*; (
	input  logic        clk,
	input  logic [31:0] a,
	input  logic [31:0] b,
	output logic [63:0] prod
);

	always_ff @(posedge clk) begin
		prod <= a * b;
	end

endmodule

FILE: rtl/core/mandelbrot_smooth_escape_time_core.sv
// sequence: accept, then the two coordinate products, then orbit passes (one
// shared 32x32 multiplier does three 64-bit squares/products in 4 partial products each,
// the pass that escapes ends after the two squares), then for an escaped pixel with |z|^2
// above 1.0 log normalization, a product and a 62-step divide, then the output register is loaded.
// pixel flow: the next pixel is taken only on return to idle, which waits for a free output.
// reset: asynchronous, clears the sequencer and output valid, loads register defaults.
module mandelbrot_smooth_escape_time_core import mset_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        pix_valid,
	output logic        pix_stall,
	input  logic [10:0] col,
	input  logic [10:0] row,
	output logic        res_valid,
	input  logic        res_stall,
	output logic [10:0] out_col,
	output logic [10:0] out_row,
	output logic        escaped,
	output logic [11:0] color_index,
	output logic [15:0] iteration_count,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  cfg_idx_t    cfg_index,
	input  logic [31:0] cfg_data
);

	state_t state_q, state_d;
	msel_t sel_q;
	logic [5:0] cnt_q;

	logic [31:0] x_min_q, y_max_q;
	logic [30:0] x_step_q, y_step_q, rad_q;
	logic [15:0] max_it_q;
	logic [12:0] cc_q;

	logic [10:0] col_q, row_q;
	logic signed [43:0] cx_q, cy_q;
	logic [63:0] x_q, y_q, x2_q, y2_q, xy_q;
	logic [15:0] passes_q;
	logic [127:0] acc_q;
	logic [63:0] norm_q;
	logic [5:0] e_q;
	logic lstage_q;
	logic [48:0] nu_q;
	logic [61:0] div_q;
	logic [15:0] rem_q;
	logic esc_q;
	logic [11:0] color_q;
	logic out_valid_q;

	logic [31:0] mul_a, mul_b;
	logic [63:0] prod;
	logic [63:0] mag_x, mag_y, ma, mb;
	logic [1:0] acc_idx;
	logic [127:0] acc_add;
	logic [63:0] mul_res;
	logic [63:0] z2_sum;
	logic [12:0] cc_m1;
	logic [11:0] top;
	logic [37:0] logv, g;
	logic [50:0] nu_s;
	logic [16:0] dtry, dsub;
	logic dge;
	logic [29:0] quot_hi;
	logic [11:0] color_fin;
	logic [63:0] xy_s;
	logic out_free;

	mset_mul u_mul (
		.clk (clk),
		.a   (mul_a),
		.b   (mul_b),
		.prod(prod)
	);

	assign cfg_ready = 1'b1;
	assign out_free = !out_valid_q || !res_stall;

	assign mag_x = x_q[63] ? (64'd0 - x_q) : x_q;
	assign mag_y = y_q[63] ? (64'd0 - y_q) : y_q;
	assign ma = (sel_q == M_YY) ? mag_y : mag_x;
	assign mb = (sel_q == M_XX) ? mag_x : mag_y;

	// partial product issued in the previous cycle is in prod now
	assign acc_idx = cnt_q[1:0] - 2'd1;
	always_comb begin
		unique case (acc_idx)
			2'd0:    acc_add = acc_q + {64'd0, prod};
			2'd3:    acc_add = acc_q + {prod, 64'd0};
			default: acc_add = acc_q + {32'd0, prod, 32'd0};
		endcase
	end
	assign mul_res = (|acc_add[127:63 + FRAC_BITS]) ? {1'b0, {63{1'b1}}}
		: acc_add[63 + FRAC_BITS:FRAC_BITS];

	assign z2_sum = x2_q + y2_q;
	assign xy_s = (x_q[63] ^ y_q[63]) ? (64'd0 - xy_q) : xy_q;

	assign cc_m1 = cc_q - 13'd1;
	assign top = (cc_q == 13'd0) ? 12'd0 : ((cc_m1 > 13'd4095) ? 12'hFFF : cc_m1[11:0]);

	assign logv = {e_q, LOG_TAB[norm_q[62 -: LOG_BITS]]};
	assign g = logv - {6'(FRAC_BITS), 32'd0};
	assign nu_s = {3'd0, passes_q, 32'd0} + {19'd0, NEG_LOG2_LN2} + {13'd0, 6'd32, 32'd0}
		- {13'd0, logv};

	assign dtry = {rem_q, div_q[61]};
	assign dsub = dtry - {1'b0, max_it_q};
	assign dge = dtry >= {1'b0, max_it_q};
	assign quot_hi = div_q[61:32];
	assign color_fin = (quot_hi > {18'd0, top}) ? top : quot_hi[11:0];

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE:  if (pix_valid) state_d = S_COORD;
			S_COORD: if (cnt_q == 6'd2) state_d = S_CHECK;
			S_CHECK: state_d = (passes_q >= max_it_q) ? S_DONE : S_MUL;
			S_MUL: begin
				if (cnt_q == 6'd4) begin
					unique case (sel_q)
						M_XX:    state_d = S_MUL;
						M_YY:    state_d = S_TEST;
						default: state_d = S_UPD;
					endcase
				end
			end
			S_TEST: begin
				if (z2_sum >= {33'd0, rad_q})
					state_d = (z2_sum > (64'd1 << FRAC_BITS)) ? S_NORM : S_DONE;
				else
					state_d = S_MUL;
			end
			S_UPD:  state_d = S_CHECK;
			S_NORM: if (norm_q[63]) state_d = S_LOG;
			S_LOG: begin
				if (lstage_q) state_d = S_PROD;
				else state_d = (g == 38'd0) ? S_DONE : S_NORM;
			end
			S_PROD: if (cnt_q == 6'd2) state_d = S_DIV;
			S_DIV:  if (cnt_q == 6'd61) state_d = S_QUO;
			S_QUO:  state_d = S_DONE;
			S_DONE: if (out_free) state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	// outputs: stall and multiplier operands
	always_comb begin
		pix_stall = (state_q != S_IDLE);
		mul_a = '0;
		mul_b = '0;
		unique case (state_q)
			S_COORD: begin
				if (cnt_q == 6'd0) begin
					mul_a = {21'd0, col_q};
					mul_b = {1'b0, x_step_q};
				end else begin
					mul_a = {21'd0, row_q};
					mul_b = {1'b0, y_step_q};
				end
			end
			S_MUL: begin
				mul_a = cnt_q[1] ? ma[63:32] : ma[31:0];
				mul_b = cnt_q[0] ? mb[63:32] : mb[31:0];
			end
			S_PROD: begin
				mul_a = (cnt_q == 6'd0) ? nu_q[31:0] : {15'd0, nu_q[48:32]};
				mul_b = {19'd0, cc_q};
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			sel_q <= M_XX;
			cnt_q <= '0;
			out_valid_q <= 1'b0;
			x_min_q <= 32'hE000_0000;
			y_max_q <= 32'd402653184;
			x_step_q <= 31'd786432;
			y_step_q <= 31'd786432;
			max_it_q <= 16'd256;
			cc_q <= 13'd256;
			rad_q <= 31'd1073741824;
		end else begin
			state_q <= state_d;
			if (state_d != state_q || (state_q == S_MUL && cnt_q == 6'd4))
				cnt_q <= '0;
			else
				cnt_q <= cnt_q + 6'd1;
			if (state_q == S_CHECK)
				sel_q <= M_XX;
			else if (state_q == S_MUL && cnt_q == 6'd4 && sel_q == M_XX)
				sel_q <= M_YY;
			else if (state_q == S_TEST)
				sel_q <= M_XY;
			if (state_q == S_DONE && out_free)
				out_valid_q <= 1'b1;
			else if (!res_stall)
				out_valid_q <= 1'b0;
			if (cfg_valid) begin
				case (cfg_index)
					CFG_X_MIN:     x_min_q <= cfg_data;
					CFG_Y_MAX:     y_max_q <= cfg_data;
					CFG_X_STEP:    x_step_q <= cfg_data[30:0];
					CFG_Y_STEP:    y_step_q <= cfg_data[30:0];
					CFG_MAX_ITER:  max_it_q <= cfg_data[15:0];
					CFG_COLORS:    cc_q <= cfg_data[12:0];
					CFG_RADIUS_SQ: rad_q <= cfg_data[30:0];
					default: ;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				col_q <= col;
				row_q <= row;
				passes_q <= '0;
				x_q <= '0;
				y_q <= '0;
				esc_q <= 1'b0;
				lstage_q <= 1'b0;
				color_q <= top;
			end
			S_COORD: begin
				if (cnt_q == 6'd1)
					cx_q <= {{12{x_min_q[31]}}, x_min_q} + $signed({2'b00, prod[41:0]});
				if (cnt_q == 6'd2)
					cy_q <= {{12{y_max_q[31]}}, y_max_q} - $signed({2'b00, prod[41:0]});
			end
			S_MUL: begin
				acc_q <= (cnt_q == 6'd0) ? 128'd0 : acc_add;
				if (cnt_q == 6'd4) begin
					unique case (sel_q)
						M_XX:    x2_q <= mul_res;
						M_YY:    y2_q <= mul_res;
						default: xy_q <= mul_res;
					endcase
				end
			end
			S_TEST: begin
				passes_q <= passes_q + 16'd1;
				norm_q <= z2_sum;
				e_q <= 6'd63;
				if (z2_sum >= {33'd0, rad_q})
					esc_q <= 1'b1;
			end
			S_UPD: begin
				x_q <= x2_q - y2_q + {{20{cx_q[43]}}, cx_q};
				y_q <= {xy_s[62:0], 1'b0} + {{20{cy_q[43]}}, cy_q};
			end
			S_NORM: begin
				if (!norm_q[63]) begin
					norm_q <= {norm_q[62:0], 1'b0};
					e_q <= e_q - 6'd1;
				end
			end
			S_LOG: begin
				if (!lstage_q) begin
					norm_q <= {26'd0, g};
					e_q <= 6'd63;
					lstage_q <= 1'b1;
				end else begin
					// negative smooth count clamps to zero
					nu_q <= nu_s[50] ? 49'd0 : nu_s[48:0];
				end
			end
			S_PROD: begin
				acc_q <= (cnt_q == 6'd0) ? 128'd0 : acc_add;
				if (cnt_q == 6'd2) begin
					div_q <= acc_add[61:0];
					rem_q <= '0;
				end
			end
			S_DIV: begin
				rem_q <= dge ? dsub[15:0] : dtry[15:0];
				div_q <= {div_q[60:0], dge};
			end
			S_QUO: color_q <= color_fin;
			S_DONE: begin
				if (out_free) begin
					out_col <= col_q;
					out_row <= row_q;
					escaped <= esc_q;
					color_index <= color_q;
					iteration_count <= passes_q;
				end
			end
			default: ;
		endcase
	end

	assign res_valid = out_valid_q;

endmodule
